// ===== hdl/ter_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the triangle edge rasterizer.
// No dependencies; used by ter_ctrl, ter_dpath and triangle_edge_rasterizer_core.
package ter_pkg;

	// Default screen size
	localparam int SCREEN_COLUMNS_DEF = 64;
	localparam int SCREEN_ROWS_DEF    = 64;

	// Fixed widths of the request and result fields
	localparam int COORD_W = 16;   // vertex coordinate, Q.4
	localparam int ROW_W   = 6;    // row and column index
	localparam int MASK_W  = 64;   // coverage mask

	// Internal arithmetic widths
	localparam int DIFF_W = COORD_W + 1;      // coordinate difference
	localparam int BOX_W  = 13;               // floor or ceiling of a coordinate
	localparam int PIX_W  = 12;               // pixel centre, Q.4, as signed
	localparam int PROD_W = DIFF_W + COORD_W; // difference times coordinate
	localparam int LANE_W = DIFF_W + PIX_W;   // difference times pixel centre
	localparam int ACC_W  = 36;               // edge value, exact

	// Triangle request
	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] third_x;
		logic signed [COORD_W-1:0] third_y;
	} vert_req_t;

	// Row result
	typedef struct packed {
		logic [ROW_W-1:0]  row_index;
		logic [MASK_W-1:0] coverage_mask;
		logic              last_row;
	} row_res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the triangle
		logic box;    // bounding box and edge deltas
		logic prod;   // edge products and column lanes
		logic base;   // row base values
		logic row;    // emit one row and advance
	} ter_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;  // clamped box holds no pixel
		logic last;   // current row is the bottom row of the box
	} ter_stat_t;

endpackage

// ===== hdl/ter_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine and result valid flag for the rasterizer.
// Depends on ter_pkg for the command and status structs.
module ter_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vert_valid,
	output logic               vert_ready,
	output logic               row_valid,
	input  logic               row_ready,
	output ter_pkg::ter_cmd_t  cmd,
	input  ter_pkg::ter_stat_t stat
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_BOX  = 5'b00010,
		S_PROD = 5'b00100,
		S_BASE = 5'b01000,
		S_ROWS = 5'b10000
	} ter_state_t;

	ter_state_t state_q, state_d;
	logic       out_valid_q;
	logic       emit;

	// Emit a row when the output register is free or being emptied
	assign emit       = (state_q == S_ROWS) && (!out_valid_q || row_ready);
	assign vert_ready = (state_q == S_IDLE);
	assign row_valid  = out_valid_q;

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = vert_valid;
				if (vert_valid) state_d = S_BOX;
			end
			S_BOX: begin
				cmd.box = 1'b1;
				state_d = S_PROD;
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d  = stat.empty ? S_IDLE : S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_ROWS;
			end
			S_ROWS: begin
				cmd.row = emit;
				if (emit && stat.last) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result valid until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (row_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/ter_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the rasterizer: bounding box, edge terms, column lanes and row output.
// Depends on ter_pkg for widths, payload types and command and status structs.
module ter_dpath #(
	parameter int SCREEN_COLUMNS = ter_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = ter_pkg::SCREEN_ROWS_DEF
) (
	input  logic               clk,
	input  ter_pkg::vert_req_t vert_data,
	input  ter_pkg::ter_cmd_t  cmd,
	output ter_pkg::ter_stat_t stat,
	output ter_pkg::row_res_t  row_data
);

	localparam int CW = ter_pkg::COORD_W;
	localparam int DW = ter_pkg::DIFF_W;
	localparam int BW = ter_pkg::BOX_W;
	localparam int XW = ter_pkg::PIX_W;
	localparam int PW = ter_pkg::PROD_W;
	localparam int LW = ter_pkg::LANE_W;
	localparam int AW = ter_pkg::ACC_W;
	localparam int RW = ter_pkg::ROW_W;
	localparam int MW = ter_pkg::MASK_W;

	localparam logic signed [BW-1:0] COL_MAX = BW'(SCREEN_COLUMNS - 1);
	localparam logic signed [BW-1:0] ROW_MAX = BW'(SCREEN_ROWS - 1);

	// Centre of column idx in Q.4
	function automatic logic signed [XW-1:0] pixel_centre(input int unsigned idx);
		pixel_centre = XW'(idx * 16 + 8);
	endfunction

	// Vertices
	logic signed [CW-1:0] vx_q [3];
	logic signed [CW-1:0] vy_q [3];

	// Box and edge deltas
	logic signed [DW-1:0] a_q [3];  // ay - by
	logic signed [DW-1:0] b_q [3];  // ax - bx
	logic [RW-1:0]        lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic                 empty_q;

	// Edge products and column lanes
	logic signed [PW-1:0] p1_q [3];  // B * by
	logic signed [PW-1:0] p2_q [3];  // bx * A
	logic signed [LW-1:0] q_q  [3];  // B * py of the top row
	logic signed [LW-1:0] e_q  [3][SCREEN_COLUMNS];  // A * px per column
	logic [SCREEN_COLUMNS-1:0] colmask_q;

	// Row walk
	logic signed [AW-1:0] r_q [3];
	logic [RW-1:0]        row_q;
	ter_pkg::row_res_t    out_q;

	// Box from vertex extremes
	logic signed [CW-1:0] mn_x, mx_x, mn_y, mx_y;
	logic signed [BW-1:0] fl_x, cl_x, fl_y, cl_y;
	logic signed [BW-1:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [XW-1:0] py0;

	always_comb begin
		mn_x = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
		mn_x = (mn_x < vx_q[2]) ? mn_x : vx_q[2];
		mx_x = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
		mx_x = (mx_x > vx_q[2]) ? mx_x : vx_q[2];
		mn_y = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
		mn_y = (mn_y < vy_q[2]) ? mn_y : vy_q[2];
		mx_y = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];
		mx_y = (mx_y > vy_q[2]) ? mx_y : vy_q[2];
		fl_x = BW'(mn_x >>> 4);
		fl_y = BW'(mn_y >>> 4);
		cl_x = BW'((DW'(mx_x) + DW'(15)) >>> 4);
		cl_y = BW'((DW'(mx_y) + DW'(15)) >>> 4);
		lo_x = (fl_x < 0) ? '0 : fl_x;
		lo_y = (fl_y < 0) ? '0 : fl_y;
		hi_x = (cl_x > COL_MAX) ? COL_MAX : cl_x;
		hi_y = (cl_y > ROW_MAX) ? ROW_MAX : cl_y;
	end

	assign py0 = $signed({2'b00, lo_y_q, 4'b1000});

	// Capture triangle, then box and edge deltas (edges 1-2, 2-3, 3-1)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vx_q[0] <= vert_data.first_x;
			vy_q[0] <= vert_data.first_y;
			vx_q[1] <= vert_data.second_x;
			vy_q[1] <= vert_data.second_y;
			vx_q[2] <= vert_data.third_x;
			vy_q[2] <= vert_data.third_y;
		end
		if (cmd.box) begin
			for (int e = 0; e < 3; e++) begin
				a_q[e] <= DW'(vy_q[e]) - DW'(vy_q[(e + 1) % 3]);
				b_q[e] <= DW'(vx_q[e]) - DW'(vx_q[(e + 1) % 3]);
			end
			lo_x_q  <= lo_x[RW-1:0];
			hi_x_q  <= hi_x[RW-1:0];
			lo_y_q  <= lo_y[RW-1:0];
			hi_y_q  <= hi_y[RW-1:0];
			empty_q <= (lo_x > hi_x) || (lo_y > hi_y);
		end
	end

	// Form edge products and per-column terms
	always_ff @(posedge clk) begin
		if (cmd.prod) begin
			for (int e = 0; e < 3; e++) begin
				p1_q[e] <= b_q[e] * vy_q[(e + 1) % 3];
				p2_q[e] <= vx_q[(e + 1) % 3] * a_q[e];
				q_q[e]  <= b_q[e] * py0;
				for (int c = 0; c < SCREEN_COLUMNS; c++) begin
					e_q[e][c] <= a_q[e] * pixel_centre(c);
				end
			end
			for (int c = 0; c < SCREEN_COLUMNS; c++) begin
				colmask_q[c] <= (RW'(c) >= lo_x_q) && (RW'(c) <= hi_x_q);
			end
		end
	end

	// Evaluate each triangle edge in every column of the current row
	logic signed [AW-1:0] d [3][SCREEN_COLUMNS];
	logic [MW-1:0]        mask;
	logic                 neg, pos;

	always_comb begin
		mask = '0;
		for (int c = 0; c < SCREEN_COLUMNS; c++) begin
			neg = 1'b0;
			pos = 1'b0;
			for (int e = 0; e < 3; e++) begin
				d[e][c] = r_q[e] + AW'(e_q[e][c]);
				neg = neg | d[e][c][AW-1];
				pos = pos | (!d[e][c][AW-1] && (d[e][c] != '0));
			end
			mask[c] = colmask_q[c] && !(neg && pos);
		end
	end

	// Set up the top row, then advance one row per emitted result
	always_ff @(posedge clk) begin
		if (cmd.base) begin
			for (int e = 0; e < 3; e++) begin
				r_q[e] <= AW'(p1_q[e]) - AW'(p2_q[e]) - AW'(q_q[e]);
			end
			row_q <= lo_y_q;
		end else if (cmd.row) begin
			for (int e = 0; e < 3; e++) begin
				r_q[e] <= r_q[e] - (AW'(b_q[e]) <<< 4);
			end
			row_q <= row_q + RW'(1);
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.row) begin
			out_q.row_index     <= row_q;
			out_q.coverage_mask <= mask;
			out_q.last_row      <= (row_q == hi_y_q);
		end
	end

	assign stat.empty = empty_q;
	assign stat.last  = (row_q == hi_y_q);
	assign row_data   = out_q;

endmodule

// ===== hdl/triangle_edge_rasterizer_core.sv =====
`timescale 1ns / 1ps
// Top level of the triangle edge rasterizer: controller plus datapath.
// Depends on ter_pkg, ter_ctrl and ter_dpath.
//
// Usage:
//   vert channel (vert_valid/vert_ready/vert_data) takes one triangle request:
//   three vertices in signed Q.4 pixels. row channel (row_valid/row_ready/
//   row_data) returns one result per row of the clamped bounding box, top to
//   bottom: row index, coverage mask of the row and a flag on the bottom row.
//   A triangle whose box misses the screen returns nothing.
// Timing:
//   After a request is taken the block passes through its setup steps (box,
//   edge products, row base) before the first row is registered. Rows then
//   follow one per cycle while row_ready does not hold them off, set by the
//   single row evaluator that tests all columns of a row at once. For an
//   off-screen triangle the block returns to idle after the edge products step.
//   vert_ready is high only between triangles; the next request may be taken
//   while the bottom row still waits in the output register.
// Stall and reset:
//   While row_ready is low the pending row is held and the row walk pauses.
//   Reset clears the controller and the result valid flag; nothing else.
module triangle_edge_rasterizer_core #(
	parameter int SCREEN_COLUMNS = ter_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = ter_pkg::SCREEN_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vert_valid,
	output logic               vert_ready,
	input  ter_pkg::vert_req_t vert_data,
	output logic               row_valid,
	input  logic               row_ready,
	output ter_pkg::row_res_t  row_data
);

	localparam logic [ter_pkg::ROW_W-1:0] ROW_LIMIT = ter_pkg::ROW_W'(SCREEN_ROWS - 1);

	ter_pkg::ter_cmd_t  cmd;
	ter_pkg::ter_stat_t stat;

	// Sequencer
	ter_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.vert_valid (vert_valid),
		.vert_ready (vert_ready),
		.row_valid  (row_valid),
		.row_ready  (row_ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Arithmetic
	ter_dpath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_dpath (
		.clk       (clk),
		.vert_data (vert_data),
		.cmd       (cmd),
		.stat      (stat),
		.row_data  (row_data)
	);

	// At most one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.box, cmd.prod, cmd.base, cmd.row}))
		else $error("more than one datapath command at once");

	// A taken request starts the box stage next
	a_load_then_box: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.box && !vert_ready)
		else $error("box stage did not follow a taken request");

	// An emitted row is presented on the next cycle
	a_row_presented: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row |=> row_valid)
		else $error("emitted row not presented");

	// Rows and columns stay on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (row_data.row_index <= ROW_LIMIT)
			&& ((row_data.coverage_mask >> SCREEN_COLUMNS) == '0))
		else $error("result outside the screen");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for triangle_edge_rasterizer_core: predicts the row masks of each
// triangle request and compares them with the rows that the block returns.
// Depends on ter_pkg and the core RTL.
module tb_top;
	import ter_pkg::*;

	localparam int COLS         = SCREEN_COLUMNS_DEF;
	localparam int ROWS         = SCREEN_ROWS_DEF;
	localparam int WATCH_LIMIT  = 2000;  // cycles with no handshake before giving up
	localparam int HOLD_CYCLES  = 200;   // long output hold-off
	localparam int DRAIN_CYCLES = 12;    // setup latency plus margin
	localparam int MAX_PRINTS   = 50;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      vert_valid = 1'b0;
	logic      row_ready  = 1'b0;
	vert_req_t vert_data  = '0;
	logic      vert_ready;
	logic      row_valid;
	row_res_t  row_data;

	row_res_t rows_due[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int stall_cycles  = 0;
	int err_cnt       = 0;
	int triangles_sent = 0;
	int offscreen_cnt  = 0;
	int rows_seen      = 0;

	triangle_edge_rasterizer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.vert_valid (vert_valid),
		.vert_ready (vert_ready),
		.vert_data  (vert_data),
		.row_valid  (row_valid),
		.row_ready  (row_ready),
		.row_data   (row_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Print one mismatch line (up to a cap) and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS) begin
			$display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
		end
	endtask

	// Work out the row masks of one triangle and queue them; return the row count
	function automatic int rasterise_rows(input vert_req_t t);
		int vx[3], vy[3];
		int lo_x, hi_x, lo_y, hi_y, n, kb;
		longint px, py, side;
		bit has_neg, has_pos;
		logic [MASK_W-1:0] mask;
		row_res_t r;
		vx[0] = $signed(t.first_x);
		vy[0] = $signed(t.first_y);
		vx[1] = $signed(t.second_x);
		vy[1] = $signed(t.second_y);
		vx[2] = $signed(t.third_x);
		vy[2] = $signed(t.third_y);
		lo_x = vx[0];
		hi_x = vx[0];
		lo_y = vy[0];
		hi_y = vy[0];
		for (int k = 1; k < 3; k++) begin
			if (vx[k] < lo_x) lo_x = vx[k];
			if (vx[k] > hi_x) hi_x = vx[k];
			if (vy[k] < lo_y) lo_y = vy[k];
			if (vy[k] > hi_y) hi_y = vy[k];
		end
		// Floor of the minimum, ceiling of the maximum, in whole pixels
		lo_x = lo_x >>> 4;
		lo_y = lo_y >>> 4;
		hi_x = (hi_x + 15) >>> 4;
		hi_y = (hi_y + 15) >>> 4;
		// Clamp to the screen; an empty box gives no rows
		if (lo_x < 0) lo_x = 0;
		if (lo_y < 0) lo_y = 0;
		if (hi_x > COLS - 1) hi_x = COLS - 1;
		if (hi_y > ROWS - 1) hi_y = ROWS - 1;
		if (lo_x > hi_x || lo_y > hi_y) return 0;
		n = 0;
		for (int row = lo_y; row <= hi_y; row++) begin
			py   = row * 16 + 8;
			mask = '0;
			for (int col = lo_x; col <= hi_x; col++) begin
				px      = col * 16 + 8;
				has_neg = 1'b0;
				has_pos = 1'b0;
				// Sample each triangle edge at the pixel centre; zero counts as inside
				for (int ka = 0; ka < 3; ka++) begin
					kb   = (ka == 2) ? 0 : ka + 1;
					side = (px - vx[kb]) * (vy[ka] - vy[kb])
						- longint'(vx[ka] - vx[kb]) * (py - vy[kb]);
					if (side < 0) has_neg = 1'b1;
					if (side > 0) has_pos = 1'b1;
				end
				mask[col] = !(has_neg && has_pos);
			end
			r.row_index     = ROW_W'(row);
			r.coverage_mask = mask;
			r.last_row      = (row == hi_y);
			rows_due.push_back(r);
			n++;
		end
		return n;
	endfunction

	function automatic vert_req_t make_triangle(input int x1, input int y1, input int x2,
			input int y2, input int x3, input int y3);
		vert_req_t t;
		t.first_x  = COORD_W'(x1);
		t.first_y  = COORD_W'(y1);
		t.second_x = COORD_W'(x2);
		t.second_y = COORD_W'(y2);
		t.third_x  = COORD_W'(x3);
		t.third_y  = COORD_W'(y3);
		return t;
	endfunction

	function automatic int sat16(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int jitter(input int centre, input int span);
		return sat16(centre + int'($urandom_range(2 * span)) - span);
	endfunction

	// Mostly small on-screen triangles, some large ones, some full-range noise
	function automatic vert_req_t random_triangle();
		int pick, cx, cy, span;
		vert_req_t t;
		pick = $urandom_range(99);
		if (pick < 10) begin
			t = vert_req_t'({$urandom(), $urandom(), $urandom()});
		end else begin
			span = (pick < 25) ? $urandom_range(4096, 512) : $urandom_range(256, 8);
			cx   = int'($urandom_range(1344)) - 160;
			cy   = int'($urandom_range(1344)) - 160;
			t = make_triangle(jitter(cx, span), jitter(cy, span), jitter(cx, span),
				jitter(cy, span), jitter(cx, span), jitter(cy, span));
		end
		return t;
	endfunction

	// Offer one request, with a random gap first, and predict its rows once taken
	task automatic send_triangle(input vert_req_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			vert_valid <= 1'b0;
			@(posedge clk);
		end
		vert_valid <= 1'b1;
		vert_data  <= t;
		do @(posedge clk); while (!vert_ready);
		if (rasterise_rows(t) == 0) offscreen_cnt++;
		triangles_sent++;
	endtask

	// Extremes, degenerate shapes, both windings and clipped boxes
	task automatic test_directed();
		send_triangle(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767));
		send_triangle(make_triangle(32767, 32767, 32767, 32767, 32767, 32767));
		send_triangle(make_triangle(-32768, -32768, -32768, -32768, -32768, -32768));
		send_triangle(make_triangle(21845, -21846, -21846, 21845, 21845, -21846));
		send_triangle(make_triangle(100, 100, 100, 100, 100, 100));
		send_triangle(make_triangle(160, 160, 160, 160, 160, 160));
		send_triangle(make_triangle(16, 16, 512, 512, 1000, 1000));
		send_triangle(make_triangle(8, 8, 72, 8, 8, 72));
		send_triangle(make_triangle(8, 8, 8, 72, 72, 8));
		send_triangle(make_triangle(900, 900, 1200, 950, 950, 1300));
		send_triangle(make_triangle(-200, -100, 300, -50, -50, 400));
		send_triangle(make_triangle(-500, 100, -20, 200, -300, 600));
		send_triangle(make_triangle(100, 1100, 300, 1200, 200, 1040));
		send_triangle(make_triangle(0, 1015, 1023, 1015, 500, 1015));
		send_triangle(make_triangle(0, 0, 1024, 0, 0, 1024));
		send_triangle(make_triangle(0, 500, 1023, 510, 0, 520));
		send_triangle(make_triangle(-32768, 0, 32767, 512, 0, 32767));
		send_triangle(make_triangle(500, -100, 520, 1100, 510, 300));
		send_triangle(make_triangle(-1, -1, 40, -1, -1, 40));
		send_triangle(make_triangle(0, 0, 1023, 8, 500, 15));
	endtask

	task automatic test_random(input int n);
		repeat (n) send_triangle(random_triangle());
	endtask

	// Hold the output off for a long stretch while requests keep coming
	task automatic test_backpressure();
		vert_valid <= 1'b0;
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		repeat (8) send_triangle(random_triangle());
	endtask

	// Drive row_ready: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			row_ready <= 1'b0;
		end else begin
			row_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each returned row against the oldest prediction
	always @(posedge clk) begin
		row_res_t want;
		if (arst_n && row_valid && row_ready) begin
			rows_seen++;
			if (rows_due.size() == 0) begin
				report_mismatch("unexpected row", 64'(row_data.row_index), 64'd0);
			end else begin
				want = rows_due.pop_front();
				if (row_data.row_index !== want.row_index)
					report_mismatch("row_index", 64'(row_data.row_index), 64'(want.row_index));
				if (row_data.coverage_mask !== want.coverage_mask)
					report_mismatch("coverage_mask", row_data.coverage_mask,
						want.coverage_mask);
				if (row_data.last_row !== want.last_row)
					report_mismatch("last_row", 64'(row_data.last_row), 64'(want.last_row));
			end
		end
	end

	// Give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (vert_valid && vert_ready) || (row_valid && row_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCH_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 12;
		recv_idle_pct = 47;
		test_directed();
		test_random(115);
		test_backpressure();

		// swap the idling
		send_idle_pct = 47;
		recv_idle_pct = 12;
		test_random(110);

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);

		// drain the remaining rows, then allow for trailing output
		vert_valid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb_top: %0d triangles (%0d off screen), %0d rows checked, %0d mismatches",
			triangles_sent, offscreen_cnt, rows_seen, err_cnt);
		$display("tb_top: covered extreme and degenerate vertices, clipped boxes,",
			" both windings, long output hold");
		if (err_cnt == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
